@@ sv/isometric_tile_blit_address_defines.svh @@
// Assertion macros for the isometric tile blit address block.
// Included by modules that carry concurrent assertions; no dependencies.
`ifndef ISOMETRIC_TILE_BLIT_ADDRESS_DEFINES_SVH
`define ISOMETRIC_TILE_BLIT_ADDRESS_DEFINES_SVH
`ifndef SYNTHESIS
`define ITBA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ITBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ITBA_ASSERT(label, clk, rstn, prop, msg)
`define ITBA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ sv/itba_pkg.sv @@
// Shared types and constants for the isometric tile blit address block.
// No dependencies.
package itba_pkg;
    localparam int MaxTilesets = 8;
    localparam int SetIdxW = $clog2(MaxTilesets);
    localparam int SetCntW = $clog2(MaxTilesets + 1);
    localparam int MaxMapCols = 1024;
    localparam int QDepth = 2;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    localparam logic [2:0] REG_BTW = 3'd0;
    localparam logic [2:0] REG_BTH = 3'd1;
    localparam logic [2:0] REG_ROWS = 3'd2;
    localparam logic [2:0] REG_SCX = 3'd3;
    localparam logic [2:0] REG_SCY = 3'd4;

    // Item decoded by the front end and queued for the back end.
    typedef struct packed {
        logic           place;     // 0: append result only
        logic           full;      // refused append
        logic           skip;      // placement that draws nothing
        logic [SetIdxW-1:0] sel;
        logic [15:0]    id;        // gid - first_gid
        logic [12:0]    iw;
        logic [12:0]    ih;
        logic [8:0]     tw;
        logic [8:0]     th;
        logic [7:0]     mg;
        logic [7:0]     sp;
        logic [9:0]     row;
        logic [9:0]     col;
    } job_t;

    typedef struct packed {
        logic        drawn;
        logic [2:0]  set_select;
        logic [12:0] src_x;
        logic [12:0] src_y;
        logic [8:0]  blit_width;
        logic [8:0]  blit_height;
        logic [20:0] dst_x;
        logic [20:0] dst_y;
        logic        table_full;
    } result_t;
endpackage

@@ sv/itba_front.sv @@
// Front end: tileset table, appends and per-tile tileset search.
// Depends on itba_pkg.
`include "isometric_tile_blit_address_defines.svh"
module itba_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [15:0]        first_gid,
    input  logic [15:0]        tile_count,
    input  logic [12:0]        image_width,
    input  logic [12:0]        image_height,
    input  logic [8:0]         set_tile_width,
    input  logic [8:0]         set_tile_height,
    input  logic [7:0]         margin,
    input  logic [7:0]         spacing,
    input  logic [15:0]        gid,
    input  logic [9:0]         map_row,
    input  logic [9:0]         map_col,
    input  logic [10:0]        map_rows,
    output logic               job_valid,
    input  logic               job_ready,
    output itba_pkg::job_t     job
);
    import itba_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_READ, S_PUSH} state_t;

    logic [31:0] range_mem [MaxTilesets];
    logic [25:0] sheet_mem [MaxTilesets];
    logic [17:0] tsize_mem [MaxTilesets];
    logic [15:0] border_mem [MaxTilesets];

    state_t state_reg;
    logic [SetCntW-1:0] count_reg;
    logic [SetCntW-1:0] idx_reg;
    logic [15:0] gid_reg;
    job_t job_reg;
    job_t job_start;
    logic table_room;
    logic early_skip;
    logic [31:0] rng_q;
    logic [25:0] sht_q;
    logic [17:0] tsz_q;
    logic [15:0] brd_q;
    logic [SetIdxW-1:0] rd_idx;
    // One past the last id of the entry being examined.
    logic [16:0] end_id;

    assign in_ready   = (state_reg == S_IDLE);
    assign job_valid  = (state_reg == S_PUSH);
    assign job        = job_reg;
    assign rd_idx     = idx_reg[SetIdxW-1:0];
    assign end_id     = {1'b0, rng_q[31:16]} + {1'b0, rng_q[15:0]};
    assign table_room = (count_reg < SetCntW'(MaxTilesets));
    assign early_skip = (gid == 16'd0 || 32'(map_col) >= MaxMapCols
                         || {1'b0, map_row} >= map_rows
                         || count_reg == '0);

    always_comb begin
        job_start       = '0;
        job_start.place = (func == FUNC_PLACE);
        job_start.full  = (func == FUNC_APPEND) && !table_room;
        job_start.skip  = (func == FUNC_PLACE) && early_skip;
        job_start.row   = map_row;
        job_start.col   = map_col;
    end

    // Registered table read; the search examines one entry per pass through S_SEARCH and S_READ.
    always_ff @(posedge aclk) begin
        rng_q <= range_mem[rd_idx];
        sht_q <= sheet_mem[rd_idx];
        tsz_q <= tsize_mem[rd_idx];
        brd_q <= border_mem[rd_idx];
        if (in_valid && in_ready && func == FUNC_APPEND && table_room) begin
            range_mem[count_reg[SetIdxW-1:0]]  <= {first_gid, tile_count};
            sheet_mem[count_reg[SetIdxW-1:0]]  <= {image_width, image_height};
            tsize_mem[count_reg[SetIdxW-1:0]]  <= {set_tile_width, set_tile_height};
            border_mem[count_reg[SetIdxW-1:0]] <= {margin, spacing};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        job_reg <= job_start;
                        gid_reg <= gid;
                        idx_reg <= '0;
                        if (func == FUNC_APPEND) begin
                            if (table_room) begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= S_PUSH;
                        end else if (early_skip) begin
                            state_reg <= S_PUSH;
                        end else begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    state_reg <= S_READ;
                end
                S_READ: begin
                    if (end_id > {1'b0, gid_reg}) begin
                        job_reg.sel <= rd_idx;
                        job_reg.id  <= gid_reg - rng_q[31:16];
                        job_reg.iw  <= sht_q[25:13];
                        job_reg.ih  <= sht_q[12:0];
                        job_reg.tw  <= tsz_q[17:9];
                        job_reg.th  <= tsz_q[8:0];
                        job_reg.mg  <= brd_q[15:8];
                        job_reg.sp  <= brd_q[7:0];
                        if (gid_reg < rng_q[31:16] || tsz_q[17:9] == '0
                            || tsz_q[8:0] == '0) begin
                            job_reg.skip <= 1'b1;
                        end
                        state_reg <= S_PUSH;
                    end else if (idx_reg + 1'b1 >= count_reg) begin
                        job_reg.skip <= 1'b1;
                        state_reg    <= S_PUSH;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SEARCH;
                    end
                end
                S_PUSH: begin
                    if (job_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ITBA_ASSERT(a_count_bound, aclk, aresetn, count_reg <= SetCntW'(MaxTilesets),
        "tileset count above table size")
    `ITBA_ASSERT(a_search_bound, aclk, aresetn,
        state_reg == S_READ |-> idx_reg < count_reg, "search past loaded sets")
    `ITBA_ASSERT(a_full_only_append, aclk, aresetn,
        job_valid && job.full |-> !job.place, "full flag on a placement")
endmodule

@@ sv/itba_queue.sv @@
// Short job queue between front and back ends.
// Depends on itba_pkg.
module itba_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  itba_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output itba_pkg::job_t rd_data
);
    import itba_pkg::*;
    localparam int PtrW = $clog2(QDepth);

    job_t slot_reg [QDepth];
    logic [PtrW-1:0] wp_reg, rp_reg;
    logic [PtrW:0]   fill_reg;
    logic push, pop;

    assign wr_ready = (fill_reg != (PtrW+1)'(QDepth));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = slot_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PtrW'(QDepth-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PtrW'(QDepth-1)) ? '0 : rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule

@@ sv/itba_back.sv @@
// Back end: shared radix-2 divider, source rectangle and screen position.
// Depends on itba_pkg.
`include "isometric_tile_blit_address_defines.svh"
module itba_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  itba_pkg::job_t    job,
    input  logic [8:0]        base_tile_width,
    input  logic [8:0]        base_tile_height,
    input  logic [10:0]       map_rows,
    input  logic [15:0]       scroll_x,
    input  logic [15:0]       scroll_y,
    output logic              res_valid,
    input  logic              res_ready,
    output itba_pkg::result_t res
);
    import itba_pkg::*;

    // Division steps: cols = iw/tw, rows = ih/th, q = id/cols (rem c),
    // then r = q mod rows.
    typedef enum logic [2:0] {
        B_IDLE, B_COLS, B_ROWS, B_IDC, B_QR, B_MUL, B_POS, B_OUT
    } state_t;

    state_t state_reg;
    job_t   job_reg;
    result_t res_reg;
    logic [15:0] num_reg, rem_reg;
    logic [15:0] den_reg;
    logic [4:0]  bit_reg;
    logic [15:0] cols_reg, rows_reg, c_reg, r_reg;
    logic [16:0] trial;
    logic [16:0] rem_sh;
    logic [20:0] px_a, px_b, py_a, py_b;
    logic [20:0] mx, my;

    assign job_ready = (state_reg == B_IDLE);
    assign res_valid = (state_reg == B_OUT);
    assign res       = res_reg;
    assign rem_sh    = {rem_reg, num_reg[15]};
    assign trial     = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        // table_full is the lowest field; only appends carry it.
                        res_reg <= {($bits(result_t)-1)'(0), job.full};
                        if (!job.place || job.skip) begin
                            state_reg <= B_OUT;
                        end else begin
                            num_reg <= {3'd0, job.iw};
                            den_reg <= {7'd0, job.tw};
                            rem_reg <= '0;
                            bit_reg <= 5'd16;
                            state_reg <= B_COLS;
                        end
                    end
                end
                B_COLS, B_ROWS, B_IDC, B_QR: begin
                    if (bit_reg != '0) begin
                        num_reg <= {num_reg[14:0], ~trial[16]};
                        rem_reg <= trial[16] ? rem_sh[15:0] : trial[15:0];
                        bit_reg <= bit_reg - 1'b1;
                    end else begin
                        rem_reg <= '0;
                        bit_reg <= 5'd16;
                        case (state_reg)
                            B_COLS: begin
                                cols_reg <= num_reg;
                                num_reg  <= {3'd0, job_reg.ih};
                                den_reg  <= {7'd0, job_reg.th};
                                state_reg <= B_ROWS;
                            end
                            B_ROWS: begin
                                rows_reg <= num_reg;
                                num_reg  <= job_reg.id;
                                den_reg  <= cols_reg;
                                if (cols_reg == '0 || num_reg == '0) begin
                                    state_reg <= B_OUT;
                                end else begin
                                    state_reg <= B_IDC;
                                end
                            end
                            B_IDC: begin
                                c_reg   <= rem_reg;
                                den_reg <= rows_reg;
                                state_reg <= B_QR;
                            end
                            default: begin
                                r_reg <= rem_reg;
                                state_reg <= B_MUL;
                            end
                        endcase
                    end
                end
                B_MUL: begin
                    res_reg.src_x <= 13'(16'(job_reg.mg)
                        + (16'(job_reg.sp) + 16'(job_reg.tw)) * c_reg);
                    res_reg.src_y <= 13'(16'(job_reg.mg)
                        + (16'(job_reg.sp) + 16'(job_reg.th)) * r_reg);
                    px_a <= 21'(map_rows) * 21'(base_tile_height);
                    px_b <= 21'(base_tile_width[8:1]) * 21'(job_reg.col);
                    mx   <= 21'(base_tile_width[8:1]) * (21'(job_reg.row) + 21'd1);
                    py_a <= 21'(base_tile_height[8:1]) * 21'(job_reg.row);
                    py_b <= 21'(base_tile_height[8:1]) * 21'(job_reg.col);
                    my   <= 21'(job_reg.th) - 21'(base_tile_height);
                    state_reg <= B_POS;
                end
                B_POS: begin
                    res_reg.drawn       <= 1'b1;
                    res_reg.set_select  <= 3'(job_reg.sel);
                    res_reg.blit_width  <= job_reg.tw;
                    res_reg.blit_height <= job_reg.th;
                    res_reg.dst_x <= px_a + px_b - mx - 21'(scroll_x);
                    res_reg.dst_y <= py_a + py_b - my - 21'(scroll_y);
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (res_ready) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    `ITBA_ASSERT(a_div_bits, aclk, aresetn, bit_reg <= 5'd16, "divider step count overrun")
    `ITBA_ASSERT(a_skip_silent, aclk, aresetn,
        res_valid && !job_reg.place |-> !res.drawn, "append result marked drawn")
    `ITBA_ASSERT(a_full_zero, aclk, aresetn,
        res_valid && res.drawn |-> !res.table_full, "full flag on a drawn tile")
endmodule

@@ sv/isometric_tile_blit_address.sv @@
// Isometric tile blit address generator: a front end holds up to eight tileset
// descriptors and finds the tileset for each placed tile; a two-entry queue
// hands decoded jobs to a back end that runs one shared 16-step restoring
// divider up to four times (sheet columns, sheet rows, id by columns,
// quotient by rows) and then forms the source rectangle and screen position.
// Every transfer on the input gives exactly one result transfer. An append
// passes through the accept and push states of the front end and the accept
// and output states of the back end. A placement is accepted, examines the
// tilesets in turn and is handed off in the front end; the back end then runs
// the divisions, the multiply and position steps and the output state. The
// divider is the limit on sustained throughput for tiles; the back end takes
// no new job until its result is taken, while the queue lets the front end
// accept further input.
// Depends on itba_pkg, itba_front, itba_queue and itba_back.
module isometric_tile_blit_address (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: first_gid, tile_count, image_width, image_height,
    // set_tile_width, set_tile_height, margin, spacing, gid, map_row, map_col
    input  logic [127:0] s_tdata,
    // tuser: func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: set_select, src_x, src_y, blit_width, blit_height,
    // dst_x, dst_y, table_full
    output logic [95:0] m_tdata,
    // tuser: drawn
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import itba_pkg::*;

    logic [8:0]  btw_reg, bth_reg;
    logic [10:0] rows_reg;
    logic [15:0] scx_reg, scy_reg;
    job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;
    result_t r;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btw_reg  <= 9'd64;
            bth_reg  <= 9'd32;
            rows_reg <= 11'd16;
            scx_reg  <= '0;
            scy_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BTW:  btw_reg  <= cfg_data[8:0];
                REG_BTH:  bth_reg  <= cfg_data[8:0];
                REG_ROWS: rows_reg <= cfg_data[10:0];
                REG_SCX:  scx_reg  <= cfg_data;
                REG_SCY:  scy_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    itba_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .func(s_tuser),
        .first_gid(s_tdata[15:0]), .tile_count(s_tdata[31:16]),
        .image_width(s_tdata[44:32]), .image_height(s_tdata[57:45]),
        .set_tile_width(s_tdata[66:58]), .set_tile_height(s_tdata[75:67]),
        .margin(s_tdata[83:76]), .spacing(s_tdata[91:84]),
        .gid(s_tdata[107:92]), .map_row(s_tdata[117:108]), .map_col(s_tdata[127:118]),
        .map_rows(rows_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    itba_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    itba_back u_back (
        .aclk, .aresetn,
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .base_tile_width(btw_reg), .base_tile_height(bth_reg),
        .map_rows(rows_reg), .scroll_x(scx_reg), .scroll_y(scy_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(r)
    );

    assign m_tuser = r.drawn;
    assign m_tdata = {6'b000000, r.table_full, r.dst_y, r.dst_x, r.blit_height,
                      r.blit_width, r.src_y, r.src_x, r.set_select};
endmodule
